FILE: design/assert_macros.svh
// Assertion macros for the scanline unfilter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("property violated");
`define ASSERT_NEVER(label, clk, rst, cond) \
   `ASSERT_PROP(label, clk, rst, !(cond))
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

FILE: design/pngunf_pkg.sv
// Types, codes and predictor functions for the PNG scanline unfilter
`timescale 1ns / 1ps
package pngunf_pkg;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   localparam logic [7:0] FILTER_CODE_MAX = 8'd4;

   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_HAS_ALPHA    = 2'd2;

   localparam int WIDTH_BITS  = 13;
   localparam int HEIGHT_BITS = 16;

   typedef struct packed {
      logic       bad;
      logic [7:0] data;
      filter_type filt;
      logic [1:0] slot;
      logic       first_pix;
      logic       above_ok;
      logic       last_col;
      logic       last_row;
   } stage_type;

   function automatic logic [9:0] mag10(input logic signed [9:0] v);
      logic signed [9:0] n;
      n = -v;
      return v[9] ? 10'(n) : 10'(v);
   endfunction

   function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [9:0] da;
      logic signed [9:0] db;
      logic signed [9:0] dc;
      logic [9:0]        pa;
      logic [9:0]        pb;
      logic [9:0]        pc;
      logic [7:0]        res;
      da = $signed({2'b00, b}) - $signed({2'b00, c});
      db = $signed({2'b00, a}) - $signed({2'b00, c});
      dc = da + db;
      pa = mag10(da);
      pb = mag10(db);
      pc = mag10(dc);
      if (pa <= pb && pa <= pc) begin
         res = a;
      end else if (pb <= pc) begin
         res = b;
      end else begin
         res = c;
      end
      return res;
   endfunction

endpackage

FILE: design/pngunf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
`timescale 1ns / 1ps
module pngunf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/png_scanline_unfilter.sv
// A sample byte is registered in stage s1 and then in the response register before its result is offered.
// Throughput: one request per clock unless results stall; a row of W pixels at B bytes each
// takes W*B+1 requests; the above-row RAM is read at accept and written as s1 advances.
// A filter-type request yields no result unless its code is bad.
// Reset is synchronous; the above-row RAM has no clearing pass, a fill count masks
// columns never written since reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module png_scanline_unfilter
   import pngunf_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixel_byte,
   output logic        rsp_row_end,
   output logic        rsp_image_end,
   output logic        rsp_bad_filter,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int DEPTH = MAX_WIDTH * 4;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = AW + 1;
   localparam int MW    = $clog2(MAX_WIDTH + 1);
   localparam int CMPW  = (WIDTH_BITS > MW) ? WIDTH_BITS : MW;

   logic [WIDTH_BITS-1:0]  image_width_ff, image_width_in;
   logic [HEIGHT_BITS-1:0] image_height_ff, image_height_in;
   logic                   has_alpha_ff, has_alpha_in;

   logic                   awaiting_ff, awaiting_in;
   logic                   error_stuck_ff, error_stuck_in;
   filter_type             row_filter_ff, row_filter_in;
   logic [AW-1:0]          col_ff, col_in;
   logic [1:0]             mod3_ff, mod3_in;
   logic [HEIGHT_BITS-1:0] row_ff, row_in;
   logic [LW-1:0]          fill_ff, fill_in;
   logic [7:0]             left_ff [4];
   logic [7:0]             left_in [4];
   logic [7:0]             uleft_ff [4];
   logic [7:0]             uleft_in [4];

   logic                   s1_valid_ff, s1_valid_in;
   stage_type              s1_ff, s1_in;
   logic [AW-1:0]          s1_col_ff, s1_col_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_pixel_ff, rsp_pixel_in;
   logic                   rsp_row_end_ff, rsp_row_end_in;
   logic                   rsp_image_end_ff, rsp_image_end_in;
   logic                   rsp_bad_ff, rsp_bad_in;

   logic                   req_accept;
   logic                   take_sample;
   logic                   take_filter;
   logic                   bad_code;
   logic                   s1_adv;
   logic                   ram_wr_en;
   logic [7:0]             ram_rd_data;

   logic [CMPW-1:0]        width_ext;
   logic [CMPW-1:0]        width_sel;
   logic [LW-1:0]          width_eff;
   logic [LW-1:0]          row_len;
   logic [HEIGHT_BITS-1:0] height_eff;
   logic                   last_col;
   logic                   last_row;
   logic                   first_pix;
   logic                   above_ok;
   logic [1:0]             slot;

   logic [7:0]             pa_b;
   logic [7:0]             pa_a;
   logic [7:0]             pa_c;
   logic [8:0]             avg_sum;
   logic [7:0]             pred;
   logic [7:0]             val;
   logic [LW-1:0]          s1_col_next;

   always_comb begin
      width_ext = CMPW'(image_width_ff);
      if (width_ext == '0) begin
         width_sel = CMPW'(1);
      end else if (width_ext > CMPW'(MAX_WIDTH)) begin
         width_sel = CMPW'(MAX_WIDTH);
      end else begin
         width_sel = width_ext;
      end
      width_eff  = LW'(width_sel);
      row_len    = has_alpha_ff ? (width_eff << 2) : ((width_eff << 1) + width_eff);
      height_eff = (image_height_ff == '0) ? HEIGHT_BITS'(1) : image_height_ff;
      last_col   = (LW'(col_ff) + LW'(1)) >= row_len;
      last_row   = ({1'b0, row_ff} + 17'd1) >= {1'b0, height_eff};
      first_pix  = has_alpha_ff ? (col_ff < AW'(4)) : (col_ff < AW'(3));
      above_ok   = (row_ff != '0) && (LW'(col_ff) < fill_ff);
      slot       = has_alpha_ff ? col_ff[1:0] : mod3_ff;
      bad_code   = req_data_byte > FILTER_CODE_MAX;
   end

   assign s1_adv      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || s1_adv;
   assign req_accept  = req_valid && req_ready;
   assign take_sample = req_accept && !error_stuck_ff && !awaiting_ff;
   assign take_filter = req_accept && !error_stuck_ff && awaiting_ff;
   assign ram_wr_en   = s1_adv && !s1_ff.bad;

   always_comb begin
      pa_b = s1_ff.above_ok ? ram_rd_data : 8'd0;
      pa_a = s1_ff.first_pix ? 8'd0 : left_ff[s1_ff.slot];
      pa_c = s1_ff.first_pix ? 8'd0 : uleft_ff[s1_ff.slot];
      avg_sum = {1'b0, pa_a} + {1'b0, pa_b};
      case (s1_ff.filt)
         FILT_NONE:  pred = 8'd0;
         FILT_SUB:   pred = pa_a;
         FILT_UP:    pred = pa_b;
         FILT_AVG:   pred = avg_sum[8:1];
         FILT_PAETH: pred = paeth_pred(pa_a, pa_b, pa_c);
         default:    pred = 8'd0;
      endcase
      val         = s1_ff.data + pred;
      s1_col_next = LW'(s1_col_ff) + LW'(1);
   end

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      has_alpha_in    = has_alpha_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_in  = csr_write_data[WIDTH_BITS-1:0];
            CSR_IMAGE_HEIGHT: image_height_in = csr_write_data[HEIGHT_BITS-1:0];
            CSR_HAS_ALPHA:    has_alpha_in    = csr_write_data[0];
            default: begin
            end
         endcase
      end

      awaiting_in    = awaiting_ff;
      error_stuck_in = error_stuck_ff;
      row_filter_in  = row_filter_ff;
      col_in         = col_ff;
      mod3_in        = mod3_ff;
      row_in         = row_ff;
      s1_in          = s1_ff;
      s1_col_in      = s1_col_ff;

      if (take_filter) begin
         if (bad_code) begin
            error_stuck_in = 1'b1;
         end else begin
            row_filter_in = filter_type'(req_data_byte[2:0]);
            awaiting_in   = 1'b0;
            col_in        = '0;
            mod3_in       = 2'd0;
         end
         s1_in           = '0;
         s1_in.bad       = 1'b1;
      end

      if (take_sample) begin
         s1_in.bad       = 1'b0;
         s1_in.data      = req_data_byte;
         s1_in.filt      = row_filter_ff;
         s1_in.slot      = slot;
         s1_in.first_pix = first_pix;
         s1_in.above_ok  = above_ok;
         s1_in.last_col  = last_col;
         s1_in.last_row  = last_row;
         s1_col_in       = col_ff;
         if (last_col) begin
            awaiting_in = 1'b1;
            col_in      = '0;
            mod3_in     = 2'd0;
            row_in      = last_row ? '0 : row_ff + HEIGHT_BITS'(1);
         end else begin
            col_in  = col_ff + AW'(1);
            mod3_in = (mod3_ff == 2'd2) ? 2'd0 : mod3_ff + 2'd1;
         end
      end

      if (take_sample || (take_filter && bad_code)) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      fill_in  = fill_ff;
      left_in  = left_ff;
      uleft_in = uleft_ff;
      if (ram_wr_en) begin
         left_in[s1_ff.slot]  = val;
         uleft_in[s1_ff.slot] = pa_b;
         if (s1_col_next > fill_ff) begin
            fill_in = s1_col_next;
         end
      end

      rsp_pixel_in     = rsp_pixel_ff;
      rsp_row_end_in   = rsp_row_end_ff;
      rsp_image_end_in = rsp_image_end_ff;
      rsp_bad_in       = rsp_bad_ff;
      if (s1_adv) begin
         rsp_valid_in     = 1'b1;
         rsp_pixel_in     = s1_ff.bad ? 8'd0 : val;
         rsp_row_end_in   = !s1_ff.bad && s1_ff.last_col;
         rsp_image_end_in = !s1_ff.bad && s1_ff.last_col && s1_ff.last_row;
         rsp_bad_in       = s1_ff.bad;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_BITS'(1);
         image_height_ff <= HEIGHT_BITS'(1);
         has_alpha_ff    <= 1'b0;
         awaiting_ff     <= 1'b1;
         error_stuck_ff  <= 1'b0;
         row_filter_ff   <= FILT_NONE;
         col_ff          <= '0;
         mod3_ff         <= 2'd0;
         row_ff          <= '0;
         fill_ff         <= '0;
         left_ff         <= '{default: 8'd0};
         uleft_ff        <= '{default: 8'd0};
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         has_alpha_ff    <= has_alpha_in;
         awaiting_ff     <= awaiting_in;
         error_stuck_ff  <= error_stuck_in;
         row_filter_ff   <= row_filter_in;
         col_ff          <= col_in;
         mod3_ff         <= mod3_in;
         row_ff          <= row_in;
         fill_ff         <= fill_in;
         left_ff         <= left_in;
         uleft_ff        <= uleft_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff            <= s1_in;
      s1_col_ff        <= s1_col_in;
      rsp_pixel_ff     <= rsp_pixel_in;
      rsp_row_end_ff   <= rsp_row_end_in;
      rsp_image_end_ff <= rsp_image_end_in;
      rsp_bad_ff       <= rsp_bad_in;
   end

   pngunf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_above_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (val),
      .rd_en   (take_sample),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = rsp_pixel_ff;
   assign rsp_row_end    = rsp_row_end_ff;
   assign rsp_image_end  = rsp_image_end_ff;
   assign rsp_bad_filter = rsp_bad_ff;

   `ASSERT_NEVER(a_stall_blocks_accept, clock, reset, s1_valid_ff && !s1_adv && req_accept)
   `ASSERT_NEVER(a_ram_no_same_addr, clock, reset, ram_wr_en && take_sample && (s1_col_ff == col_ff))
   `ASSERT_PROP(a_error_sticks, clock, reset, error_stuck_ff |=> error_stuck_ff)
   `ASSERT_NEVER(a_fill_bounded, clock, reset, fill_ff > LW'(DEPTH))

endmodule

FILE: tb/sv/png_scanline_unfilter_checker.sv
// Checker for the PNG scanline unfilter: predicts each reconstructed byte and compares results
`timescale 1ns / 1ps
module png_scanline_unfilter_checker
   import pngunf_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_pixel_byte,
   input  logic        rsp_row_end,
   input  logic        rsp_image_end,
   input  logic        rsp_bad_filter,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data,
   output int          mismatch_count,
   output int          pending_count,
   output int          checked_count
);

   localparam int ROW_STORE_DEPTH = MAX_WIDTH * 4;
   localparam int RGB_BYTES       = 3;
   localparam int RGBA_BYTES      = 4;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       row_end;
      logic       image_end;
      logic       bad_filter;
   } unfiltered_byte_type;

   unfiltered_byte_type expected_bytes[$];

   logic [7:0]  prev_row [ROW_STORE_DEPTH];
   logic [7:0]  left_px [4];
   logic [7:0]  upleft_px [4];
   logic [13:0] column;
   logic [15:0] row;
   filter_type  row_filt;
   logic        want_filter;
   logic        locked_out;

   logic [WIDTH_BITS-1:0]  width_reg;
   logic [HEIGHT_BITS-1:0] height_reg;
   logic                   alpha_reg;

   function automatic logic [7:0] paeth_guess(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
      int pa;
      int pb;
      int pc;
      pa = int'(b) - int'(c);
      pb = int'(a) - int'(c);
      pc = int'(a) + int'(b) - 2 * int'(c);
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
   endfunction

   task automatic queue_expected(input unfiltered_byte_type res);
      expected_bytes = {expected_bytes, res};
   endtask

   task automatic predict_request(input logic [7:0] x);
      int                  bpp;
      int                  eff_w;
      int                  eff_h;
      int                  row_len;
      int                  col;
      int                  slot;
      logic [7:0]          a;
      logic [7:0]          b;
      logic [7:0]          c;
      logic [7:0]          guess;
      logic [7:0]          val;
      logic                last_col;
      logic                last_row;
      unfiltered_byte_type res;
      if (locked_out) return;
      if (want_filter) begin
         if (x > FILTER_CODE_MAX) begin
            locked_out = 1'b1;
            res = '{pixel_byte: 8'd0, row_end: 1'b0, image_end: 1'b0, bad_filter: 1'b1};
            queue_expected(res);
         end else begin
            row_filt = filter_type'(x[2:0]);
            want_filter = 1'b0;
            column = '0;
         end
         return;
      end
      bpp = alpha_reg ? RGBA_BYTES : RGB_BYTES;
      eff_w = (width_reg == 0) ? 1 : int'(width_reg);
      if (eff_w > MAX_WIDTH) eff_w = MAX_WIDTH;
      eff_h = (height_reg == 0) ? 1 : int'(height_reg);
      row_len = eff_w * bpp;
      col = int'(column);
      slot = col % bpp;
      if (col < bpp) begin
         a = 8'd0;
         c = 8'd0;
      end else begin
         a = left_px[slot];
         c = upleft_px[slot];
      end
      b = (row != 0 && col < ROW_STORE_DEPTH) ? prev_row[col] : 8'd0;
      case (row_filt)
         FILT_SUB:   guess = a;
         FILT_UP:    guess = b;
         FILT_AVG:   guess = 8'((9'(a) + 9'(b)) >> 1);
         FILT_PAETH: guess = paeth_guess(a, b, c);
         default:    guess = 8'd0;
      endcase
      val = x + guess;
      left_px[slot] = val;
      upleft_px[slot] = b;
      if (col < ROW_STORE_DEPTH) prev_row[col] = val;
      last_col = (col + 1 >= row_len);
      last_row = (int'(row) + 1 >= eff_h);
      res = '{pixel_byte: val, row_end: last_col, image_end: last_col && last_row,
              bad_filter: 1'b0};
      queue_expected(res);
      if (last_col) begin
         want_filter = 1'b1;
         column = '0;
         row = last_row ? 16'd0 : row + 16'd1;
      end else begin
         column = column + 14'd1;
      end
   endtask

   always @(posedge clock) begin : track
      unfiltered_byte_type want;
      if (reset) begin
         for (int i = 0; i < ROW_STORE_DEPTH; i++) prev_row[i] = 8'd0;
         for (int i = 0; i < 4; i++) begin
            left_px[i] = 8'd0;
            upleft_px[i] = 8'd0;
         end
         column = '0;
         row = '0;
         row_filt = FILT_NONE;
         want_filter = 1'b1;
         locked_out = 1'b0;
         width_reg = WIDTH_BITS'(1);
         height_reg = HEIGHT_BITS'(1);
         alpha_reg = 1'b0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("result with no request pending: pixel_byte %0d bad_filter %0b",
                      rsp_pixel_byte, rsp_bad_filter);
               mismatch_count++;
            end else begin
               want = expected_bytes.pop_front();
               checked_count++;
               if (rsp_pixel_byte !== want.pixel_byte) begin
                  $error("pixel_byte expected %0d got %0d", want.pixel_byte, rsp_pixel_byte);
                  mismatch_count++;
               end
               if (rsp_row_end !== want.row_end) begin
                  $error("row_end expected %0b got %0b", want.row_end, rsp_row_end);
                  mismatch_count++;
               end
               if (rsp_image_end !== want.image_end) begin
                  $error("image_end expected %0b got %0b", want.image_end, rsp_image_end);
                  mismatch_count++;
               end
               if (rsp_bad_filter !== want.bad_filter) begin
                  $error("bad_filter expected %0b got %0b", want.bad_filter, rsp_bad_filter);
                  mismatch_count++;
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_reg = csr_write_data[WIDTH_BITS-1:0];
               CSR_IMAGE_HEIGHT: height_reg = csr_write_data[HEIGHT_BITS-1:0];
               CSR_HAS_ALPHA:    alpha_reg = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_request(req_data_byte);
      end
      pending_count = expected_bytes.size();
   end

endmodule

FILE: tb/sv/png_scanline_unfilter_tb.sv
// Testbench top for the PNG scanline unfilter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module png_scanline_unfilter_tb
   import pngunf_pkg::*;
();

   localparam int MAX_PIXELS       = 4096;
   localparam int RGB_BYTES        = 3;
   localparam int RGBA_BYTES       = 4;
   localparam int RANDOM_REQUESTS  = 1150;
   localparam int DRAIN_CYCLES     = 8;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int STALL_LIMIT      = 3000;
   localparam int WIDE_PART_BYTES  = 40;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_pixel_byte;
   logic        rsp_row_end;
   logic        rsp_image_end;
   logic        rsp_bad_filter;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_write_data;

   int mismatch_count;
   int pending_count;
   int checked_count;

   int requests_sent  = 0;
   int settings_used  = 0;
   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   bit long_hold_req  = 1'b0;

   logic [WIDTH_BITS-1:0]  img_w = WIDTH_BITS'(1);
   logic [HEIGHT_BITS-1:0] img_h = HEIGHT_BITS'(1);
   logic                   img_alpha = 1'b0;
   bit                     at_row_start = 1'b1;
   int                     row_col = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   png_scanline_unfilter DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_row_end    (rsp_row_end),
      .rsp_image_end  (rsp_image_end),
      .rsp_bad_filter (rsp_bad_filter),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   png_scanline_unfilter_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_row_end    (rsp_row_end),
      .rsp_image_end  (rsp_image_end),
      .rsp_bad_filter (rsp_bad_filter),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   function automatic int row_bytes();
      int w;
      w = (img_w == 0) ? 1 : int'(img_w);
      if (w > MAX_PIXELS) w = MAX_PIXELS;
      return w * (img_alpha ? RGBA_BYTES : RGB_BYTES);
   endfunction

   function automatic logic [7:0] random_sample();
      case ($urandom_range(0, 3))
         0:       return 8'($urandom_range(0, 3));
         1:       return 8'($urandom_range(252, 255));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_request(input logic [7:0] b);
      if (sender_idles && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < 30);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_filter(input filter_type f);
      send_request({5'd0, f});
      at_row_start = 1'b0;
      row_col = 0;
   endtask

   task automatic send_sample(input logic [7:0] b);
      send_request(b);
      if (row_col + 1 >= row_bytes()) begin
         at_row_start = 1'b1;
         row_col = 0;
      end else begin
         row_col++;
      end
   endtask

   // send n bytes packed high byte first
   task automatic send_packed(input logic [63:0] bytes, input int n);
      for (int i = n - 1; i >= 0; i--) send_sample(bytes[8*i +: 8]);
   endtask

   task automatic send_rows(input int n, input int cut_pct);
      int cut;
      int k;
      for (int r = 0; r < n; r++) begin
         if (at_row_start) send_filter(filter_type'($urandom_range(0, 4)));
         cut = ($urandom_range(0, 99) < cut_pct) ? $urandom_range(0, row_bytes() - 1) : -1;
         k = 0;
         while (!at_row_start) begin
            if (k == cut) return;
            send_sample(random_sample());
            k++;
         end
      end
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_image_regs(input logic [15:0] w, input logic [15:0] h, input logic a,
                                 input logic [2:0] which);
      logic [1:0]  codes [3];
      logic [15:0] vals [3];
      codes[0] = CSR_IMAGE_WIDTH;
      codes[1] = CSR_IMAGE_HEIGHT;
      codes[2] = CSR_HAS_ALPHA;
      vals[0] = w;
      vals[1] = h;
      vals[2] = {15'd0, a};
      for (int i = 0; i < 3; i++) begin
         if (which[i]) begin
            csr_write_en <= 1'b1;
            csr_index <= codes[i];
            csr_write_data <= vals[i];
            @(negedge clock);
         end
      end
      csr_write_en <= 1'b0;
      if (which[0]) img_w = w[WIDTH_BITS-1:0];
      if (which[1]) img_h = h[HEIGHT_BITS-1:0];
      if (which[2]) img_alpha = a;
      settings_used++;
   endtask

   initial begin : rsp_side
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ready <= !receiver_idles || ($urandom_range(0, 99) >= 30);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      int random_start;
      int r;
      logic [15:0] w;
      logic [15:0] h;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'd0;
      csr_write_en = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_write_data = 16'd0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, every filter, height zero, mid-row width shrink
      set_image_regs(16'd1, 16'd2, 1'b0, 3'b111);
      send_filter(FILT_NONE);
      send_packed(64'hFF0080, 3);
      send_filter(FILT_UP);
      send_packed(64'h01FF80, 3);
      pause_until_drained();
      set_image_regs(16'd2, 16'd0, 1'b1, 3'b111);
      send_filter(FILT_PAETH);
      send_packed(64'hFF007F8001FE00FF, 8);
      pause_until_drained();
      set_image_regs(16'd3, 16'd2, 1'b0, 3'b111);
      send_filter(FILT_SUB);
      send_packed(64'h10F0_0102, 4);
      pause_until_drained();
      set_image_regs(16'd1, 16'd0, 1'b0, 3'b001);
      send_sample(8'h33);
      send_filter(FILT_AVG);
      send_packed(64'hFE0181, 3);

      // fill the block while the receiver holds off
      pause_until_drained();
      set_image_regs(16'd16, 16'd2, 1'b1, 3'b111);
      long_hold_req = 1'b1;
      send_rows(2, 0);

      // stretch with no idling on either side
      pause_until_drained();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      set_image_regs(16'd5, 16'd3, 1'b0, 3'b111);
      send_rows(6, 0);
      pause_until_drained();
      sender_idles = 1'b1;
      receiver_idles = 1'b1;

      random_start = requests_sent;
      while (requests_sent - random_start < RANDOM_REQUESTS) begin
         pause_until_drained();
         r = $urandom_range(0, 99);
         w = (r < 5) ? 16'd0 : (r < 12) ? 16'($urandom_range(7, 40)) : 16'($urandom_range(1, 6));
         r = $urandom_range(0, 99);
         h = (r < 5) ? 16'd0 : (r < 10) ? 16'hFFFF : 16'($urandom_range(1, 3));
         set_image_regs(w, h, 1'($urandom_range(0, 1)),
                        ($urandom_range(0, 99) < 70) ? 3'b111 : 3'($urandom_range(1, 7)));
         send_rows($urandom_range(1, 6), 10);
      end

      // width register saturates to the maximum; then shrink it so the next byte ends the row
      send_rows(at_row_start ? 0 : 1, 0);
      pause_until_drained();
      set_image_regs(16'hFFFF, 16'd2, 1'b1, 3'b111);
      send_filter(FILT_PAETH);
      for (int i = 0; i < WIDE_PART_BYTES; i++) send_sample(random_sample());
      pause_until_drained();
      set_image_regs(16'd1, 16'd2, 1'b1, 3'b001);
      send_sample(random_sample());

      // bad filter code locks the block; later requests are dropped
      pause_until_drained();
      send_request(FILTER_CODE_MAX + 8'd1);
      send_request(8'd0);
      send_request(8'($urandom));
      send_request(8'hFF);
      send_request(8'd3);

      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      $display("Covered %0d requests and %0d checked results over %0d register settings,",
               requests_sent, checked_count, settings_used);
      $display("with all five filters, saturated and shrunk width, zero height and lockout.");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/pngunf_pkg.sv
design/pngunf_ram.sv
design/png_scanline_unfilter.sv
tb/sv/png_scanline_unfilter_checker.sv
tb/sv/png_scanline_unfilter_tb.sv
